// ===== hdl/ewt_pkg.sv =====
// shared types, constants and tables for the ego-to-world point transform
`default_nettype none

package ewt_pkg;

    // rotator depth, limited to the range the arctangent and gain tables cover
    localparam int ROTATION_STAGES = 16;
    localparam int STAGES = (ROTATION_STAGES < 8) ? 8 :
                            (ROTATION_STAGES > 32) ? 32 : ROTATION_STAGES;

    // widths
    localparam int COORD_W = 32;   // Q15.16 coordinate
    localparam int HEAD_W  = 16;   // binary angle heading
    localparam int ROT_W   = 32;   // rotator x/y in Q1.30
    localparam int ANG_W   = 32;   // residual angle in 32 bit binary angle units
    localparam int CS_W    = ROT_W + 1;            // cosine/sine after quadrant fix
    localparam int PROD_W  = CS_W + COORD_W;       // exact product
    localparam int SUM_W   = PROD_W + 1;           // sum of two products plus bias
    localparam int ROUND_SHIFT = 30;
    localparam int ROT_OUT_W = SUM_W - ROUND_SHIFT; // rotated coordinate before offset
    localparam int WORLD_W   = ROT_OUT_W + 1;       // rotated coordinate plus pose

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic        [HEAD_W-1:0]  heading_t;
    typedef logic signed [ROT_W-1:0]   rot_t;
    typedef logic signed [ANG_W-1:0]   angle_t;
    typedef logic signed [CS_W-1:0]    cs_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;

    // quadrant of the heading
    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    // point data that travels alongside the angle
    typedef struct packed {
        coord_t ex;
        coord_t ey;
        coord_t ez;
        coord_t px;
        coord_t py;
    } point_t;

    // arctangent of 2^-i in 32 bit binary angle units
    localparam logic [ANG_W-1:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // inverse rotator gain in Q30 for 8 to 16 stages, 16 and above share the last
    localparam logic [ROT_W-1:0] GAIN_TAB [9] = '{
        32'd652039507, 32'd652034532, 32'd652033289, 32'd652032978,
        32'd652032900, 32'd652032881, 32'd652032876, 32'd652032874,
        32'd652032874
    };
    localparam int GAIN_IDX = (STAGES >= 16) ? 8 : (STAGES - 8);

    // rounding bias, one half of the output LSB in the product scale
    localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) << (ROUND_SHIFT - 1);

endpackage

`default_nettype wire

// ===== hdl/ego_to_world_point_transform.sv =====
// top level of the ego-to-world point transform
//
// Converts a point given relative to the robot into world coordinates:
// x and y are rotated by the robot heading and offset by the pose
// position, z passes through. Coordinates are signed Q15.16, the heading
// is a 16 bit binary angle (65536 is a full turn). Sums that overflow
// saturate to the 32 bit signed range.
// Input: an item is taken on each rising edge where start is high and
// busy is low. busy is always low, so an item may be issued every cycle.
// Output: each result sits on world_x, world_y and world_z for one cycle
// with done high; the receiver must take it then.
// Path: an accepted item passes through one angle set-up stage, 16
// rotator stages, a quadrant fix-up stage, a product stage, a sum stage
// and an output stage.
// Throughput: one item per cycle, set by the fully pipelined rotator.
// Reset clears all stage valid bits, so no result appears until items
// are issued after reset; items in flight at reset are dropped.
`default_nettype none

module ego_to_world_point_transform (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire ewt_pkg::coord_t   ego_x,
    input  wire ewt_pkg::coord_t   ego_y,
    input  wire ewt_pkg::coord_t   ego_z,
    input  wire ewt_pkg::coord_t   pose_x,
    input  wire ewt_pkg::coord_t   pose_y,
    input  wire ewt_pkg::heading_t pose_heading,
    output logic                   done,
    output ewt_pkg::coord_t        world_x,
    output ewt_pkg::coord_t        world_y,
    output ewt_pkg::coord_t        world_z
);

    logic            accept;
    ewt_pkg::point_t in_point;
    logic            cs_valid;
    ewt_pkg::cs_t    cos_val;
    ewt_pkg::cs_t    sin_val;
    ewt_pkg::point_t cs_point;

    // pipeline never stalls
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // bundle the point data that rides with the angle
    always_comb
    begin
        in_point.ex = ego_x;
        in_point.ey = ego_y;
        in_point.ez = ego_z;
        in_point.px = pose_x;
        in_point.py = pose_y;
    end

    // cosine and sine of the heading
    ewt_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .heading   (pose_heading),
        .in_point  (in_point),
        .out_valid (cs_valid),
        .cos_val   (cos_val),
        .sin_val   (sin_val),
        .out_point (cs_point)
    );

    // rotate, translate and saturate
    ewt_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cs_valid),
        .cos_val   (cos_val),
        .sin_val   (sin_val),
        .in_point  (cs_point),
        .out_valid (done),
        .world_x   (world_x),
        .world_y   (world_y),
        .world_z   (world_z)
    );

endmodule

`default_nettype wire

// ===== hdl/ewt_cordic.sv =====
// pipelined rotator producing cosine and sine of the heading, point data alongside
`default_nettype none

module ewt_cordic (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire ewt_pkg::heading_t heading,
    input  wire ewt_pkg::point_t   in_point,
    output logic                   out_valid,
    output ewt_pkg::cs_t           cos_val,
    output ewt_pkg::cs_t           sin_val,
    output ewt_pkg::point_t        out_point
);

    localparam int N = ewt_pkg::STAGES;

    // per-stage registers, index 0 is the angle set-up stage
    logic              v_reg [0:N];
    ewt_pkg::rot_t     x_reg [0:N];
    ewt_pkg::rot_t     y_reg [0:N];
    ewt_pkg::angle_t   r_reg [0:N];
    ewt_pkg::quad_t    q_reg [0:N];
    ewt_pkg::point_t   p_reg [0:N];

    logic [ewt_pkg::HEAD_W-1:0] head_bias;
    ewt_pkg::quad_t             q_next;
    ewt_pkg::angle_t            r_next;

    // quadrant split and residual angle in [-pi/4, pi/4)
    always_comb
    begin
        head_bias = heading + ewt_pkg::HEAD_W'(16'h2000);
        q_next    = ewt_pkg::quad_t'(head_bias[ewt_pkg::HEAD_W-1 -: 2]);
        r_next    = ewt_pkg::angle_t'({heading, 16'b0} - {q_next, 30'b0});
    end

    // set-up stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0] <= ewt_pkg::rot_t'(ewt_pkg::GAIN_TAB[ewt_pkg::GAIN_IDX]);
        y_reg[0] <= '0;
        r_reg[0] <= r_next;
        q_reg[0] <= q_next;
        p_reg[0] <= in_point;
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < N; i++)
    begin : g_stage
        ewt_pkg::rot_t   dx;
        ewt_pkg::rot_t   dy;
        ewt_pkg::rot_t   x_next;
        ewt_pkg::rot_t   y_next;
        ewt_pkg::angle_t ri_next;

        always_comb
        begin
            dx = y_reg[i] >>> i;
            dy = x_reg[i] >>> i;
            if (!r_reg[i][ewt_pkg::ANG_W-1])
            begin
                x_next  = x_reg[i] - dx;
                y_next  = y_reg[i] + dy;
                ri_next = r_reg[i] - ewt_pkg::angle_t'(ewt_pkg::ATAN_TAB[i]);
            end
            else
            begin
                x_next  = x_reg[i] + dx;
                y_next  = y_reg[i] - dy;
                ri_next = r_reg[i] + ewt_pkg::angle_t'(ewt_pkg::ATAN_TAB[i]);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[i+1] <= x_next;
            y_reg[i+1] <= y_next;
            r_reg[i+1] <= ri_next;
            q_reg[i+1] <= q_reg[i];
            p_reg[i+1] <= p_reg[i];
        end
    end

    // quadrant fix-up by swap and negate
    ewt_pkg::cs_t    c_next;
    ewt_pkg::cs_t    s_next;
    ewt_pkg::cs_t    xe;
    ewt_pkg::cs_t    ye;
    logic            vo_reg;
    ewt_pkg::cs_t    c_reg;
    ewt_pkg::cs_t    s_reg;
    ewt_pkg::point_t po_reg;

    always_comb
    begin
        xe = ewt_pkg::cs_t'(x_reg[N]);
        ye = ewt_pkg::cs_t'(y_reg[N]);
        case (q_reg[N])
            ewt_pkg::QUAD_0:
            begin
                c_next = xe;
                s_next = ye;
            end
            ewt_pkg::QUAD_1:
            begin
                c_next = -ye;
                s_next = xe;
            end
            ewt_pkg::QUAD_2:
            begin
                c_next = -xe;
                s_next = -ye;
            end
            default:
            begin
                c_next = ye;
                s_next = -xe;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else
        begin
            vo_reg <= v_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg  <= c_next;
        s_reg  <= s_next;
        po_reg <= p_reg[N];
    end

    assign out_valid = vo_reg;
    assign cos_val   = c_reg;
    assign sin_val   = s_reg;
    assign out_point = po_reg;

endmodule

`default_nettype wire

// ===== hdl/ewt_mac.sv =====
// rotate-and-translate arithmetic: products, rounded sums, pose offset and saturation
`default_nettype none

module ewt_mac (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire ewt_pkg::cs_t    cos_val,
    input  wire ewt_pkg::cs_t    sin_val,
    input  wire ewt_pkg::point_t in_point,
    output logic                 out_valid,
    output ewt_pkg::coord_t      world_x,
    output ewt_pkg::coord_t      world_y,
    output ewt_pkg::coord_t      world_z
);

    typedef logic signed [ewt_pkg::ROT_OUT_W-1:0] rot_out_t;
    typedef logic signed [ewt_pkg::WORLD_W-1:0]   world_t;

    localparam world_t SAT_MAX = world_t'({1'b0, {(ewt_pkg::COORD_W-1){1'b1}}});
    localparam world_t SAT_MIN = -SAT_MAX - world_t'(1);

    // clamp to the coordinate range
    function automatic ewt_pkg::coord_t sat_coord(input world_t v);
        ewt_pkg::coord_t res;
        if (v > SAT_MAX)
        begin
            res = ewt_pkg::coord_t'(SAT_MAX);
        end
        else if (v < SAT_MIN)
        begin
            res = ewt_pkg::coord_t'(SAT_MIN);
        end
        else
        begin
            res = ewt_pkg::coord_t'(v);
        end
        return res;
    endfunction

    // stage 1: four exact products
    ewt_pkg::prod_t  cx_next, sy_next, sx_next, cy_next;
    logic            v1_reg;
    ewt_pkg::prod_t  cx_reg, sy_reg, sx_reg, cy_reg;
    ewt_pkg::point_t p1_reg;

    assign cx_next = cos_val * in_point.ex;
    assign sy_next = sin_val * in_point.ey;
    assign sx_next = sin_val * in_point.ex;
    assign cy_next = cos_val * in_point.ey;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg <= cx_next;
        sy_reg <= sy_next;
        sx_reg <= sx_next;
        cy_reg <= cy_next;
        p1_reg <= in_point;
    end

    // stage 2: rotated sums with rounding bias
    ewt_pkg::sum_t   rx_sum_next, ry_sum_next;
    logic            v2_reg;
    ewt_pkg::sum_t   rx_sum_reg, ry_sum_reg;
    ewt_pkg::point_t p2_reg;

    assign rx_sum_next = ewt_pkg::sum_t'(cx_reg) - ewt_pkg::sum_t'(sy_reg)
                       + ewt_pkg::sum_t'(ewt_pkg::ROUND_BIAS);
    assign ry_sum_next = ewt_pkg::sum_t'(sx_reg) + ewt_pkg::sum_t'(cy_reg)
                       + ewt_pkg::sum_t'(ewt_pkg::ROUND_BIAS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rx_sum_reg <= rx_sum_next;
        ry_sum_reg <= ry_sum_next;
        p2_reg     <= p1_reg;
    end

    // stage 3: scale back to Q15.16, add pose, saturate
    rot_out_t        rx, ry;
    world_t          wx_next, wy_next;
    logic            v3_reg;
    ewt_pkg::coord_t wx_reg, wy_reg, wz_reg;

    always_comb
    begin
        rx      = rot_out_t'(rx_sum_reg[ewt_pkg::SUM_W-1:ewt_pkg::ROUND_SHIFT]);
        ry      = rot_out_t'(ry_sum_reg[ewt_pkg::SUM_W-1:ewt_pkg::ROUND_SHIFT]);
        wx_next = world_t'(rx) + world_t'(p2_reg.px);
        wy_next = world_t'(ry) + world_t'(p2_reg.py);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        wx_reg <= sat_coord(wx_next);
        wy_reg <= sat_coord(wy_next);
        wz_reg <= p2_reg.ez;
    end

    assign out_valid = v3_reg;
    assign world_x   = wx_reg;
    assign world_y   = wy_reg;
    assign world_z   = wz_reg;

endmodule

`default_nettype wire
